// ===== rtl/trcb_pkg.sv =====
// ----------------------------------------------------------------------------
// Timed relay channel bank package
// Shared types and constants for the relay bank and its channel interfaces.
// ----------------------------------------------------------------------------
package trcb_pkg;

  // Number of relay positions in the result masks and id registers.
  localparam int unsigned TRCB_BANK_MAX = 2;

  localparam int unsigned TRCB_ID_W   = 8;
  localparam int unsigned TRCB_SECS_W = 8;
  localparam int unsigned TRCB_MAX_W  = 7;
  localparam int unsigned TRCB_CNT_W  = 8;
  localparam int unsigned TRCB_IDX_W  = 2;
  localparam int unsigned TRCB_DATA_W = 8;

  localparam logic [TRCB_ID_W-1:0]  TRCB_CH0_ID_RST = 8'd1;
  localparam logic [TRCB_ID_W-1:0]  TRCB_CH1_ID_RST = 8'd3;
  localparam logic [TRCB_MAX_W-1:0] TRCB_MAX_ON_RST = 7'd60;

  typedef enum logic {
    KIND_CMD  = 1'b0,
    KIND_TICK = 1'b1
  } trcb_kind_e;

  typedef enum logic [TRCB_IDX_W-1:0] {
    REG_CH0_ID = 2'd0,
    REG_CH1_ID = 2'd1,
    REG_MAX_ON = 2'd2
  } trcb_reg_e;

  typedef struct packed {
    trcb_kind_e             kind;
    logic [TRCB_ID_W-1:0]   device_id;
    logic [TRCB_SECS_W-1:0] on_seconds;
  } trcb_item_t;

  typedef struct packed {
    logic [TRCB_BANK_MAX-1:0] relay_mask;
    logic                     matched;
    logic [TRCB_BANK_MAX-1:0] timeout_mask;
  } trcb_result_t;

endpackage

// ===== rtl/trcb_if.sv =====
// ----------------------------------------------------------------------------
// Timed relay channel bank interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface trcb_item_if;
  import trcb_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic [TRCB_ID_W-1:0]   device_id;
  logic [TRCB_SECS_W-1:0] on_seconds;

  modport source (output valid, output kind, output device_id, output on_seconds,
                  input ready);
  modport sink (input valid, input kind, input device_id, input on_seconds,
                output ready);
endinterface

interface trcb_result_if;
  import trcb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [TRCB_BANK_MAX-1:0] relay_mask;
  logic                     matched;
  logic [TRCB_BANK_MAX-1:0] timeout_mask;

  modport source (output valid, output relay_mask, output matched,
                  output timeout_mask, input ready);
  modport sink (input valid, input relay_mask, input matched, input timeout_mask,
                output ready);
endinterface

interface trcb_cfg_if;
  import trcb_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [TRCB_IDX_W-1:0]  index;
  logic [TRCB_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/timed_relay_channel_bank_top.sv =====
// ----------------------------------------------------------------------------
// Timed relay channel bank
// Relay outputs with per-channel fail-safe countdown timers.
// ----------------------------------------------------------------------------
// Usage: item_i carries either a command (device id and on time in seconds)
// or a half-second tick. Every item yields exactly one result on result_o:
// the relay states after the item, whether a command matched a channel, and
// which channels a tick switched off by timeout. cfg_i writes the two channel
// id registers and the on-time clamp; it is always ready. It must be written
// only while the bank is idle, which the block itself does not enforce.
// An accepted item is held in the input register; the channel update and the
// result are then computed in one pass into the state and result registers,
// which drive result_o. One item is taken every cycle while the receiver does
// not stall; the channel update is the only work per item.
// When the receiver stalls, the result register holds and the input register
// fills; item_i.ready then drops until the result is taken.
// Reset clears all counters and relays, loads the default ids and clamp, and
// empties both registers.
// ----------------------------------------------------------------------------
module timed_relay_channel_bank_top #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  trcb_item_if.sink     item_i,
  trcb_result_if.source result_o,
  trcb_cfg_if.sink      cfg_i
);
  import trcb_pkg::*;

  // Configuration registers
  logic [TRCB_ID_W-1:0]  chan_id_q [TRCB_BANK_MAX];
  logic [TRCB_MAX_W-1:0] max_on_q;

  // Channel state
  logic [CHANNELS-1:0]   relay_on_q, relay_on_d;
  logic [TRCB_CNT_W-1:0] cnt_q [CHANNELS];
  logic [TRCB_CNT_W-1:0] cnt_d [CHANNELS];

  // Input register and result register
  logic         in_valid_q, in_valid_d;
  trcb_item_t   in_q;
  logic         res_valid_q;
  trcb_result_t res_q, res_d;
  trcb_kind_e   res_kind_q;

  logic advance;
  logic in_fire;
  logic upd_fire;

  assign advance  = !res_valid_q || result_o.ready;
  assign item_i.ready = !in_valid_q || advance;
  assign in_fire  = item_i.valid && item_i.ready;
  assign upd_fire = in_valid_q && advance;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_id_q[0] <= TRCB_CH0_ID_RST;
      chan_id_q[1] <= TRCB_CH1_ID_RST;
      max_on_q     <= TRCB_MAX_ON_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_CH0_ID: chan_id_q[0] <= cfg_i.data;
        REG_CH1_ID: chan_id_q[1] <= cfg_i.data;
        REG_MAX_ON: max_on_q     <= cfg_i.data[TRCB_MAX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) begin
      in_valid_d = in_fire;
    end else if (in_fire) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.kind       <= trcb_kind_e'(item_i.kind);
      in_q.device_id  <= item_i.device_id;
      in_q.on_seconds <= item_i.on_seconds;
    end
  end

  // Channel update for the item held in the input register.
  always_comb begin
    logic                  found;
    logic [TRCB_MAX_W-1:0] secs_clamped;

    found        = 1'b0;
    relay_on_d   = relay_on_q;
    res_d        = '0;
    secs_clamped = (in_q.on_seconds > {1'b0, max_on_q}) ? max_on_q
                                                         : in_q.on_seconds[TRCB_MAX_W-1:0];
    for (int c = 0; c < CHANNELS; c++) begin
      cnt_d[c] = cnt_q[c];
    end

    if (in_q.kind == KIND_TICK) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (cnt_q[c] != '0) begin
          cnt_d[c] = cnt_q[c] - 1'b1;
        end else if (relay_on_q[c]) begin
          relay_on_d[c]        = 1'b0;
          res_d.timeout_mask[c] = 1'b1;
        end
      end
    end else begin
      // The lowest channel whose id matches takes the command.
      for (int c = 0; c < CHANNELS; c++) begin
        if (!found && chan_id_q[c] == in_q.device_id) begin
          found         = 1'b1;
          cnt_d[c]      = {secs_clamped, 1'b0};
          relay_on_d[c] = (secs_clamped != '0);
        end
      end
    end

    res_d.matched = found;
    for (int c = 0; c < CHANNELS; c++) begin
      res_d.relay_mask[c] = relay_on_d[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_on_q <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        cnt_q[c] <= '0;
      end
    end else if (upd_fire) begin
      relay_on_q <= relay_on_d;
      for (int c = 0; c < CHANNELS; c++) begin
        cnt_q[c] <= cnt_d[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      res_q      <= res_d;
      res_kind_q <= in_q.kind;
    end
  end

  assign result_o.valid        = res_valid_q;
  assign result_o.relay_mask   = res_q.relay_mask;
  assign result_o.matched      = res_q.matched;
  assign result_o.timeout_mask = res_q.timeout_mask;

`ifndef SYNTH
  // Only a tick can time a relay out.
  a_timeout_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.timeout_mask != '0 |-> res_kind_q == KIND_TICK)
    else $error("timeout reported for a command");

  // Only a command can match a channel.
  a_match_on_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.matched |-> res_kind_q == KIND_CMD)
    else $error("match reported for a tick");

  // A channel that timed out is reported off.
  a_timeout_is_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.timeout_mask & res_q.relay_mask) == '0)
    else $error("timed-out channel still on");

  // A running counter on channel 0 always belongs to a relay that is on.
  a_count_implies_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] != '0 |-> relay_on_q[0])
    else $error("channel 0 counting with relay off");

  // State changes only when an item is processed.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(upd_fire) |-> $stable(relay_on_q))
    else $error("relay state changed without an item");
`endif

endmodule

// ===== bench/timed_relay_channel_bank_top_test.sv =====
// ----------------------------------------------------------------------------
// Timed relay channel bank testbench
// Drives command and tick items into the relay bank with random bursts and
// receiver stalls, predicts each result with a model of the channel counters
// and relays, and compares every result field by field in order. The run
// covers default and extreme register settings, id collisions, clamping,
// timeouts and a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module timed_relay_channel_bank_top_test;
  import trcb_pkg::*;

  localparam int unsigned BANK_CHANNELS  = 2;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          PHASE_ITEMS    = 240;

  // Register index past the last implemented register; writes to it are dropped.
  localparam logic [TRCB_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  trcb_item_if   item_bus ();
  trcb_result_if result_bus ();
  trcb_cfg_if    cfg_bus ();

  timed_relay_channel_bank_top #(
    .CHANNELS(BANK_CHANNELS)
  ) i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_bus),
    .result_o(result_bus),
    .cfg_i   (cfg_bus)
  );

  // Predicted register and channel state.
  logic [TRCB_ID_W-1:0]  chan_id        [TRCB_BANK_MAX];
  logic [TRCB_MAX_W-1:0] max_on_secs;
  logic [TRCB_CNT_W-1:0] half_secs_left [TRCB_BANK_MAX];
  logic                  relay_state    [TRCB_BANK_MAX];

  trcb_result_t expected_relay_results[$];
  int           mismatch_count;
  int           quiet_cycles;

  // Traffic shaping shared between the stimulus and the receiver.
  bit sender_lazy;
  bit rx_choppy;
  int burst_left;
  int holdoff_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic trcb_result_t relay_bank_step(input trcb_item_t it);
    trcb_result_t           res;
    logic [TRCB_SECS_W-1:0] secs;
    res = '0;
    if (it.kind == KIND_TICK) begin
      for (int c = 0; c < BANK_CHANNELS; c++) begin
        if (half_secs_left[c] != '0) begin
          half_secs_left[c] = half_secs_left[c] - 1'b1;
        end else if (relay_state[c]) begin
          relay_state[c]      = 1'b0;
          res.timeout_mask[c] = 1'b1;
        end
      end
    end else begin
      // The lowest channel with a matching id takes the command.
      for (int c = 0; c < BANK_CHANNELS; c++) begin
        if (!res.matched && chan_id[c] == it.device_id) begin
          secs = (it.on_seconds > max_on_secs) ? {1'b0, max_on_secs} : it.on_seconds;
          half_secs_left[c] = {secs[TRCB_SECS_W-2:0], 1'b0};
          relay_state[c]    = (secs != '0);
          res.matched       = 1'b1;
        end
      end
    end
    for (int c = 0; c < BANK_CHANNELS; c++) res.relay_mask[c] = relay_state[c];
    return res;
  endfunction

  function automatic trcb_item_t mk_item(input trcb_kind_e k, input logic [7:0] id,
                                         input logic [7:0] secs);
    trcb_item_t it;
    it.kind       = k;
    it.device_id  = id;
    it.on_seconds = secs;
    return it;
  endfunction

  // Commands aimed at configured ids with mostly short times, mixed with slightly
  // more ticks so that counters run out, plus some stray ids and full-range times.
  function automatic trcb_item_t make_traffic_item();
    trcb_item_t it;
    int         pick;
    it.kind       = ($urandom_range(0, 99) < 55) ? KIND_TICK : KIND_CMD;
    it.device_id  = 8'($urandom_range(0, 255));
    it.on_seconds = 8'($urandom_range(0, 255));
    if (it.kind == KIND_CMD) begin
      if ($urandom_range(0, 99) < 85) begin
        it.device_id = chan_id[1'($urandom_range(0, BANK_CHANNELS - 1))];
      end
      pick = $urandom_range(0, 9);
      if (pick < 2) it.on_seconds = '0;
      else if (pick < 7) it.on_seconds = 8'($urandom_range(1, 8));
    end
    return it;
  endfunction

  task automatic send_item(input trcb_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_lazy ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        item_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_bus.valid      <= 1'b1;
    item_bus.kind       <= it.kind;
    item_bus.device_id  <= it.device_id;
    item_bus.on_seconds <= it.on_seconds;
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
    expected_relay_results.push_back(relay_bank_step(it));
  endtask

  task automatic wait_results_drained();
    item_bus.valid <= 1'b0;
    burst_left = 0;
    while (expected_relay_results.size() != 0) @(posedge clk);
    // Leave a little margin after the last result has been taken.
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [TRCB_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    unique case (idx)
      REG_CH0_ID: chan_id[0] = data;
      REG_CH1_ID: chan_id[1] = data;
      REG_MAX_ON: max_on_secs = data[TRCB_MAX_W-1:0];
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [7:0] id0, input logic [7:0] id1,
                               input logic [7:0] max_on);
    wait_results_drained();
    write_reg(REG_CH0_ID, id0);
    write_reg(REG_CH1_ID, id1);
    write_reg(REG_MAX_ON, max_on);
  endtask

  task automatic test_defaults_and_timeout();
    sender_lazy = 1'b0;
    rx_choppy   = 1'b1;
    send_item(mk_item(KIND_CMD, 8'd1, 8'd0));
    send_item(mk_item(KIND_CMD, 8'd1, 8'd255));
    send_item(mk_item(KIND_CMD, 8'd3, 8'd1));
    send_item(mk_item(KIND_CMD, 8'd0, 8'd200));
    send_item(mk_item(KIND_CMD, 8'd255, 8'd128));
    // Ticks ignore their id and time fields.
    send_item(mk_item(KIND_TICK, 8'hFF, 8'hFF));
    send_item(mk_item(KIND_TICK, 8'h00, 8'h00));
    send_item(mk_item(KIND_TICK, 8'h5A, 8'hA5));
    send_item(mk_item(KIND_TICK, 8'h00, 8'h00));
    send_item(mk_item(KIND_CMD, 8'd1, 8'd0));
    send_item(mk_item(KIND_TICK, 8'h00, 8'h00));
  endtask

  task automatic test_register_extremes();
    // Both ids equal: channel 0 must win. The top data bit of the clamp is dropped.
    load_settings(8'h55, 8'h55, 8'hFF);
    write_reg(REG_UNUSED, 8'hAA);
    send_item(mk_item(KIND_CMD, 8'h55, 8'd255));
    send_item(mk_item(KIND_CMD, 8'h55, 8'd3));
    load_settings(8'h55, 8'h55, 8'h00);
    send_item(mk_item(KIND_CMD, 8'h55, 8'd200));
    load_settings(8'h00, 8'hFF, 8'h81);
    send_item(mk_item(KIND_CMD, 8'h00, 8'd9));
    send_item(mk_item(KIND_CMD, 8'hFF, 8'd1));
    repeat (3) send_item(mk_item(KIND_TICK, 8'h00, 8'h00));
  endtask

  task automatic test_random_traffic();
    logic [7:0] same_id;
    for (int phase = 0; phase < 8; phase++) begin
      unique case (phase)
        0: load_settings(TRCB_CH0_ID_RST, TRCB_CH1_ID_RST, {1'b0, TRCB_MAX_ON_RST});
        1: load_settings(8'h00, 8'hFF, 8'h7F);
        2: load_settings(8'hFF, 8'h00, 8'h01);
        3: begin
          same_id = 8'($urandom_range(0, 255));
          load_settings(same_id, same_id, 8'h00);
        end
        default: begin
          load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        {1'($urandom_range(0, 1)), 7'($urandom_range(0, 6))});
          write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
        end
      endcase
      sender_lazy = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      rx_choppy   = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      repeat (PHASE_ITEMS) send_item(make_traffic_item());
    end
  endtask

  task automatic test_receiver_holdoff();
    load_settings(8'd1, 8'd3, 8'd4);
    sender_lazy  = 1'b0;
    rx_choppy    = 1'b0;
    holdoff_left = 300;
    repeat (40) send_item(make_traffic_item());
    // Sender pauses here until every outstanding result has been taken.
    wait_results_drained();
    rx_choppy = 1'b1;
    repeat (20) send_item(make_traffic_item());
  endtask

  // Receiver: ready by default, a rotating random stall pattern when choppy,
  // and a counted hold-off on request.
  initial begin
    logic [15:0] stall_bits;
    int          pattern_age;
    stall_bits  = '0;
    pattern_age = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_left > 0) begin
        holdoff_left--;
        result_bus.ready <= 1'b0;
      end else if (rx_choppy) begin
        if (pattern_age == 0) begin
          stall_bits  = 16'($urandom);
          pattern_age = 48;
        end
        pattern_age--;
        result_bus.ready <= !stall_bits[0];
        stall_bits = {stall_bits[0], stall_bits[15:1]};
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    trcb_result_t want;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (expected_relay_results.size() == 0) begin
        $error("result with no item pending: relay_mask %0h matched %0b timeout_mask %0h",
               result_bus.relay_mask, result_bus.matched, result_bus.timeout_mask);
        mismatch_count++;
      end else begin
        want = expected_relay_results.pop_front();
        if (result_bus.relay_mask !== want.relay_mask) begin
          $error("relay_mask: expected %0h, got %0h", want.relay_mask, result_bus.relay_mask);
          mismatch_count++;
        end
        if (result_bus.matched !== want.matched) begin
          $error("matched: expected %0b, got %0b", want.matched, result_bus.matched);
          mismatch_count++;
        end
        if (result_bus.timeout_mask !== want.timeout_mask) begin
          $error("timeout_mask: expected %0h, got %0h", want.timeout_mask,
                 result_bus.timeout_mask);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (item_bus.valid && item_bus.ready) ||
        (result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timed_relay_channel_bank_top_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    item_bus.valid      <= 1'b0;
    item_bus.kind       <= KIND_CMD;
    item_bus.device_id  <= '0;
    item_bus.on_seconds <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_CH0_ID;
    cfg_bus.data  <= '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    sender_lazy    = 1'b0;
    rx_choppy      = 1'b0;
    burst_left     = 0;
    holdoff_left   = 0;
    chan_id[0]     = TRCB_CH0_ID_RST;
    chan_id[1]     = TRCB_CH1_ID_RST;
    max_on_secs    = TRCB_MAX_ON_RST;
    for (int c = 0; c < TRCB_BANK_MAX; c++) begin
      half_secs_left[c] = '0;
      relay_state[c]    = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults_and_timeout();
    test_register_extremes();
    test_random_traffic();
    test_receiver_holdoff();

    wait_results_drained();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && expected_relay_results.size() == 0) begin
      $display("timed_relay_channel_bank_top_test: done, clean");
    end else begin
      $display("timed_relay_channel_bank_top_test: done, errors");
    end
    $finish;
  end

endmodule
